// ===== hw/rtl/pft_pkg.sv =====
// ----------------------------------------------------------------------------
// pft_pkg: shared types and constants of the polygon fan triangulator
// Item opcodes, result status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package pft_pkg;

  // item opcodes; code 3 carries no meaning and is ignored
  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_HEADER = 2'd1;
  localparam logic [1:0] OP_CORNER = 2'd2;

  typedef enum logic [1:0] {
    ST_TRIANGLE  = 2'd0,
    ST_DROP_FACE = 2'd1,
    ST_OVERRUN   = 2'd2,
    ST_TOO_LARGE = 2'd3
  } status_e;

  // configuration register indexes
  localparam logic REG_NUM_POINTS  = 1'b0;
  localparam logic REG_NUM_INDICES = 1'b1;

  localparam int unsigned CfgIdxWidth  = 1;
  localparam int unsigned DataWidth    = 32;
  // smallest face that yields a fan triangle
  localparam int unsigned MinFanCorners = 3;

endpackage

// ===== hw/rtl/pft_ram.sv =====
// ----------------------------------------------------------------------------
// pft_ram: generic single-write, single-read synchronous ram
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pft_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/polygon_fan_triangulator.sv =====
// ----------------------------------------------------------------------------
// polygon_fan_triangulator: turns a stream of polygon faces into fan triangles
// Collects the corners of each face in a corner ram and emits the fan
// triangles (first, c-1, c) of a good face, or a status beat on errors.
// ----------------------------------------------------------------------------
// Begin-mesh, face header and corner beats are taken whenever the block is not
// emitting and the output register is free or draining. When the last corner
// of a good face of n > 2 corners arrives, the block stops taking input and
// emits the n-2 triangles from the corner ram, each by a ram read in S_RD and
// then registering the result in S_OUT, which waits while the output side
// stalls; the triangles are read one at a time through the single read port
// of the corner ram. A bad face gives one drop status beat, an index overrun
// or an oversized face gives one halt status beat after which headers and
// corners are ignored until the next begin-mesh. The corner ram needs no
// clearing pass after reset: only corners of the current face are read.
// num_points and num_indices must be written through the config port while
// the block is idle; this binds the user, the block does not enforce it.
module polygon_fan_triangulator #(
  parameter int unsigned MAX_FACE = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [pft_pkg::CfgIdxWidth-1:0]      cfg_idx_i,
  input  logic [pft_pkg::DataWidth-1:0]        cfg_data_i,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           op_i,
  input  logic [pft_pkg::DataWidth-1:0]        face_count_i,
  input  logic [pft_pkg::DataWidth-1:0]        vertex_index_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [1:0]                           status_o,
  output logic [pft_pkg::DataWidth-1:0]        corner_a_o,
  output logic [pft_pkg::DataWidth-1:0]        corner_b_o,
  output logic [pft_pkg::DataWidth-1:0]        corner_c_o,
  output logic                                 last_o
);

  localparam int unsigned DW = pft_pkg::DataWidth;
  // corner ram address width and corner count width (counts reach MAX_FACE)
  localparam int unsigned AW = $clog2(MAX_FACE);
  localparam int unsigned CW = $clog2(MAX_FACE + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // taking input beats
  localparam logic [1:0] S_RD   = 2'd1;  // read corner c from the ram
  localparam logic [1:0] S_OUT  = 2'd2;  // register triangle c

  // configuration registers
  logic [DW-1:0] num_points_q, num_indices_q;

  // face tracking state
  logic [1:0]    state_q, state_d;
  logic [CW-1:0] expected_q, expected_d;
  logic [CW-1:0] received_q, received_d;
  logic          face_good_q, face_good_d;
  logic          face_open_q, face_open_d;
  logic [DW:0]   offset_q, offset_d;
  logic          halted_q, halted_d;
  logic [CW-1:0] c_q, c_d;

  // fan corners kept outside the ram: first corner and corner c-1
  logic [DW-1:0] first_q, first_d;
  logic [DW-1:0] prev_q, prev_d;

  // output register
  logic          out_valid_q, out_valid_d;
  logic [1:0]    status_q, status_d;
  logic [DW-1:0] a_q, a_d, b_q, b_d, cc_q, cc_d;
  logic          last_q, last_d;

  // corner ram
  logic          ram_we, ram_re;
  logic [DW-1:0] ram_rdata;

  logic          in_fire, out_free;
  logic [DW+1:0] end_sum;
  logic [CW-1:0] received_inc;
  logic          corner_good;
  logic          tri_last;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_fire    = in_valid_i && !in_stall_o;

  assign end_sum      = {1'b0, offset_q} + {2'b00, face_count_i};
  assign received_inc = received_q + CW'(1);
  assign corner_good  = face_good_q && (vertex_index_i < num_points_q);
  assign tri_last     = (c_q + CW'(1)) == expected_q;

  // corners are written only while a face is open, so the address stays below MAX_FACE
  assign ram_we = in_fire && (op_i == pft_pkg::OP_CORNER) && !halted_q && face_open_q;
  assign ram_re = (state_q == S_RD);

  pft_ram #(
    .Width (DW),
    .Depth (MAX_FACE)
  ) u_corner_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (received_q[AW-1:0]),
    .wdata_i (vertex_index_i),
    .re_i    (ram_re),
    .raddr_i (c_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q  <= '0;
      num_indices_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pft_pkg::REG_NUM_POINTS:  num_points_q  <= cfg_data_i;
        pft_pkg::REG_NUM_INDICES: num_indices_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    expected_d  = expected_q;
    received_d  = received_q;
    face_good_d = face_good_q;
    face_open_d = face_open_q;
    offset_d    = offset_q;
    halted_d    = halted_q;
    c_d         = c_q;
    first_d     = first_q;
    prev_d      = prev_q;

    // output register drains when the consumer takes the beat
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    a_d         = a_q;
    b_d         = b_q;
    cc_d        = cc_q;
    last_d      = last_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (op_i)
            pft_pkg::OP_BEGIN: begin
              expected_d  = '0;
              received_d  = '0;
              face_good_d = 1'b1;
              face_open_d = 1'b0;
              offset_d    = '0;
              halted_d    = 1'b0;
            end
            pft_pkg::OP_HEADER: begin
              if (!halted_q) begin
                // any open face is abandoned; its indices stay counted
                face_open_d = 1'b0;
                received_d  = '0;
                expected_d  = '0;
                face_good_d = 1'b1;
                if (end_sum > {2'b00, num_indices_q}) begin
                  // overrun is checked before face size
                  halted_d    = 1'b1;
                  out_valid_d = 1'b1;
                  status_d    = pft_pkg::ST_OVERRUN;
                  a_d         = '0;
                  b_d         = '0;
                  cc_d        = '0;
                  last_d      = 1'b1;
                end else if (face_count_i > DW'(MAX_FACE)) begin
                  halted_d    = 1'b1;
                  out_valid_d = 1'b1;
                  status_d    = pft_pkg::ST_TOO_LARGE;
                  a_d         = '0;
                  b_d         = '0;
                  cc_d        = '0;
                  last_d      = 1'b1;
                end else begin
                  offset_d    = end_sum[DW:0];
                  expected_d  = face_count_i[CW-1:0];
                  face_open_d = (face_count_i != '0);
                end
              end
            end
            pft_pkg::OP_CORNER: begin
              // stray corners (halted or no open face) are ignored
              if (!halted_q && face_open_q) begin
                face_good_d = corner_good;
                received_d  = received_inc;
                if (received_q == '0) begin
                  first_d = vertex_index_i;
                end
                if (received_q == CW'(1)) begin
                  prev_d = vertex_index_i;
                end
                if (received_inc >= expected_q) begin
                  face_open_d = 1'b0;
                  if (!corner_good) begin
                    out_valid_d = 1'b1;
                    status_d    = pft_pkg::ST_DROP_FACE;
                    a_d         = '0;
                    b_d         = '0;
                    cc_d        = '0;
                    last_d      = 1'b1;
                  end else if (expected_q >= CW'(pft_pkg::MinFanCorners)) begin
                    // start the fan at corner 2; corner 1 is already in prev
                    c_d     = CW'(2);
                    state_d = S_RD;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        // ram data holds until the next read, so a stalled output just waits
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = pft_pkg::ST_TRIANGLE;
          a_d         = first_q;
          b_d         = prev_q;
          cc_d        = ram_rdata;
          last_d      = tri_last;
          prev_d      = ram_rdata;
          c_d         = c_q + CW'(1);
          state_d     = tri_last ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      expected_q  <= '0;
      received_q  <= '0;
      face_good_q <= 1'b1;
      face_open_q <= 1'b0;
      offset_q    <= '0;
      halted_q    <= 1'b0;
      c_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      expected_q  <= expected_d;
      received_q  <= received_d;
      face_good_q <= face_good_d;
      face_open_q <= face_open_d;
      offset_q    <= offset_d;
      halted_q    <= halted_d;
      c_q         <= c_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    prev_q   <= prev_d;
    status_q <= status_d;
    a_q      <= a_d;
    b_q      <= b_d;
    cc_q     <= cc_d;
    last_q   <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign corner_a_o  = a_q;
  assign corner_b_o  = b_q;
  assign corner_c_o  = cc_q;
  assign last_o      = last_q;

  // an open face never holds more corners than its header announced
  a_open_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    face_open_q |-> (received_q < expected_q))
    else $error("open face holds too many corners");

  // a halt closes the face
  a_halt_closed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !face_open_q)
    else $error("face open while halted");

  // fan emission only runs over corners of a face of three or more
  a_fan_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> ((c_q < expected_q) && (c_q >= CW'(2))))
    else $error("fan corner out of range");

endmodule
